[sv/dnsb_pkg.sv]
// Shared types, constants and helper functions for the dual nearest scale blend block.
package dnsb_pkg;

  localparam int SRC_MAX_DIM = 256;
  localparam int COORD_W     = $clog2(SRC_MAX_DIM);
  localparam int SIZE_W      = COORD_W + 1;
  localparam int OUT_W       = 12;
  localparam int MUL_W       = OUT_W + SIZE_W;
  localparam int PROD_W      = OUT_W + COORD_W;
  localparam int ADDR_W      = 2 * COORD_W;
  localparam int BYTE_W      = 8;
  localparam int PIX_W       = 3 * BYTE_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = OUT_W;
  localparam int DIV_LAT     = COORD_W + 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [SIZE_W-1:0] SRC_MAX_SIZE = SIZE_W'(SRC_MAX_DIM);
  localparam logic [SIZE_W-1:0] SRC_SIZE_RST = SIZE_W'(256);
  localparam logic [OUT_W-1:0]  OUT_W_RST    = OUT_W'(1366);
  localparam logic [OUT_W-1:0]  OUT_H_RST    = OUT_W'(768);

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_RENDER = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC0_WIDTH  = 3'd0,
    CFG_SRC0_HEIGHT = 3'd1,
    CFG_SRC1_WIDTH  = 3'd2,
    CFG_SRC1_HEIGHT = 3'd3,
    CFG_OUT_WIDTH   = 3'd4,
    CFG_OUT_HEIGHT  = 3'd5
  } cfg_idx_e;

  // Sizes as used by the scaler, already clamped to their legal ranges.
  typedef struct packed {
    logic [SIZE_W-1:0] src0_w;
    logic [SIZE_W-1:0] src0_h;
    logic [SIZE_W-1:0] src1_w;
    logic [SIZE_W-1:0] src1_h;
    logic [OUT_W-1:0]  out_w;
    logic [OUT_W-1:0]  out_h;
  } dnsb_sizes_t;

  // One classified item as it waits in the queue between front and back.
  typedef struct packed {
    logic              render;
    logic              sel;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
    logic [PROD_W-1:0] col0;
    logic [PROD_W-1:0] row0;
    logic [PROD_W-1:0] col1;
    logic [PROD_W-1:0] row1;
  } dnsb_item_t;

  function automatic logic [SIZE_W-1:0] fit_src(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SRC_MAX_SIZE) begin
      r = SRC_MAX_SIZE;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] fit_out(input logic [OUT_W-1:0] v);
    logic [OUT_W-1:0] r;
    r = (v == '0) ? OUT_W'(1) : v;
    return r;
  endfunction

endpackage

[sv/dnsb_front.sv]
// Front end: classifies an incoming item and forms the scaled coordinate products.
module dnsb_front (
  input  logic                        func_i,
  input  logic                        src_sel_i,
  input  logic [dnsb_pkg::COORD_W-1:0] src_col_i,
  input  logic [dnsb_pkg::COORD_W-1:0] src_row_i,
  input  logic [dnsb_pkg::BYTE_W-1:0]  wr_byte0_i,
  input  logic [dnsb_pkg::BYTE_W-1:0]  wr_byte1_i,
  input  logic [dnsb_pkg::BYTE_W-1:0]  wr_byte2_i,
  input  logic [dnsb_pkg::OUT_W-1:0]   out_col_i,
  input  logic [dnsb_pkg::OUT_W-1:0]   out_row_i,
  input  dnsb_pkg::dnsb_sizes_t        sizes_i,
  output dnsb_pkg::dnsb_item_t         item_o
);
  import dnsb_pkg::*;

  logic [MUL_W-1:0] col0_full;
  logic [MUL_W-1:0] row0_full;
  logic [MUL_W-1:0] col1_full;
  logic [MUL_W-1:0] row1_full;

  // The products never exceed PROD_W bits since the source size is at most SRC_MAX_DIM.
  assign col0_full = MUL_W'(out_col_i) * MUL_W'(sizes_i.src0_w);
  assign row0_full = MUL_W'(out_row_i) * MUL_W'(sizes_i.src0_h);
  assign col1_full = MUL_W'(out_col_i) * MUL_W'(sizes_i.src1_w);
  assign row1_full = MUL_W'(out_row_i) * MUL_W'(sizes_i.src1_h);

  always_comb begin
    item_o.render = (func_i == FUNC_RENDER);
    item_o.sel    = src_sel_i;
    item_o.addr   = {src_row_i, src_col_i};
    item_o.pix    = {wr_byte2_i, wr_byte1_i, wr_byte0_i};
    item_o.col0   = col0_full[PROD_W-1:0];
    item_o.row0   = row0_full[PROD_W-1:0];
    item_o.col1   = col1_full[PROD_W-1:0];
    item_o.row1   = row1_full[PROD_W-1:0];
  end

endmodule

[sv/dnsb_queue.sv]
// Short queue that decouples the front end from the scaling back end.
module dnsb_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dnsb_pkg::dnsb_item_t item_i,
  input  logic                 pop_i,
  output dnsb_pkg::dnsb_item_t item_o,
  output logic                 valid_o,
  output logic                 full_o
);
  import dnsb_pkg::*;

  dnsb_item_t        slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign item_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[sv/dnsb_div.sv]
// Pipelined restoring divider that maps a scaled coordinate to a clamped source index.
module dnsb_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [dnsb_pkg::PROD_W-1:0]  numer_i,
  input  logic [dnsb_pkg::OUT_W-1:0]   denom_i,
  input  logic [dnsb_pkg::SIZE_W-1:0]  size_i,
  output logic [dnsb_pkg::COORD_W-1:0] quot_o
);
  import dnsb_pkg::*;

  localparam int STAGES = COORD_W;

  logic [PROD_W-1:0]  rem_q [STAGES+1];
  logic [COORD_W-1:0] quo_q [STAGES+1];
  logic               ovf_q [STAGES+1];
  logic [COORD_W-1:0] quot_q;
  logic [PROD_W-1:0]  denom_top;
  logic [SIZE_W-1:0]  size_m1;
  logic               sat;

  // A quotient of SRC_MAX_DIM or more always saturates, so only COORD_W bits are developed.
  assign denom_top = PROD_W'(denom_i) << STAGES;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= numer_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (numer_i >= denom_top);
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_bit
    logic [PROD_W-1:0] dsh;
    logic              ge;
    assign dsh = PROD_W'(denom_i) << (STAGES - 1 - k);
    assign ge  = (rem_q[k] >= dsh);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? rem_q[k] - dsh : rem_q[k];
        quo_q[k+1] <= {quo_q[k][COORD_W-2:0], ge};
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign size_m1 = size_i - SIZE_W'(1);
  assign sat     = ovf_q[STAGES] || ({1'b0, quo_q[STAGES]} >= size_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= sat ? size_m1[COORD_W-1:0] : quo_q[STAGES];
    end
  end

  assign quot_o = quot_q;

endmodule

[sv/dnsb_back.sv]
// Back end: coordinate division, source image memories and the blend output register.
module dnsb_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  dnsb_pkg::dnsb_item_t        item_i,
  output logic                        take_o,
  input  dnsb_pkg::dnsb_sizes_t       sizes_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [dnsb_pkg::BYTE_W-1:0] px_byte0_o,
  output logic [dnsb_pkg::BYTE_W-1:0] px_byte1_o,
  output logic [dnsb_pkg::BYTE_W-1:0] px_byte2_o
);
  import dnsb_pkg::*;

  localparam int MEM_DEPTH = 1 << ADDR_W;

  typedef struct packed {
    logic              render;
    logic              sel;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
  } side_t;

  logic               advance;
  logic               sb_valid_q [DIV_LAT];
  side_t              sb_q       [DIV_LAT];
  logic [COORD_W-1:0] col0, row0, col1, row1;
  logic               mem_wr;
  logic               mem_rd_valid_q;
  logic [PIX_W-1:0]   mem0 [MEM_DEPTH];
  logic [PIX_W-1:0]   mem1 [MEM_DEPTH];
  logic [PIX_W-1:0]   rd0_q, rd1_q;
  logic               out_valid_q;
  logic [PIX_W-1:0]   px_q;
  logic [PIX_W-1:0]   blend;

  // The whole back pipeline moves together whenever the output register can take a value.
  assign advance = !out_valid_q || !out_stall_i;
  assign take_o  = advance && valid_i;

  dnsb_div u_div_col0 (
    .clk_i, .en_i(advance), .numer_i(item_i.col0), .denom_i(sizes_i.out_w),
    .size_i(sizes_i.src0_w), .quot_o(col0)
  );
  dnsb_div u_div_row0 (
    .clk_i, .en_i(advance), .numer_i(item_i.row0), .denom_i(sizes_i.out_h),
    .size_i(sizes_i.src0_h), .quot_o(row0)
  );
  dnsb_div u_div_col1 (
    .clk_i, .en_i(advance), .numer_i(item_i.col1), .denom_i(sizes_i.out_w),
    .size_i(sizes_i.src1_w), .quot_o(col1)
  );
  dnsb_div u_div_row1 (
    .clk_i, .en_i(advance), .numer_i(item_i.row1), .denom_i(sizes_i.out_h),
    .size_i(sizes_i.src1_h), .quot_o(row1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        sb_valid_q[i] <= 1'b0;
      end
    end else if (advance) begin
      sb_valid_q[0] <= valid_i;
      for (int i = 1; i < DIV_LAT; i++) begin
        sb_valid_q[i] <= sb_valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sb_q[0] <= '{render: item_i.render, sel: item_i.sel, addr: item_i.addr,
                   pix: item_i.pix};
      for (int i = 1; i < DIV_LAT; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  // Writes take effect at the same stage where renders read, so program order holds.
  assign mem_wr = advance && sb_valid_q[DIV_LAT-1] && !sb_q[DIV_LAT-1].render;

  always_ff @(posedge clk_i) begin
    if (mem_wr && !sb_q[DIV_LAT-1].sel) begin
      mem0[sb_q[DIV_LAT-1].addr] <= sb_q[DIV_LAT-1].pix;
    end
    if (advance) begin
      rd0_q <= mem0[{row0, col0}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr && sb_q[DIV_LAT-1].sel) begin
      mem1[sb_q[DIV_LAT-1].addr] <= sb_q[DIV_LAT-1].pix;
    end
    if (advance) begin
      rd1_q <= mem1[{row1, col1}];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [BYTE_W:0] sum;
      sum = {1'b0, rd0_q[k*BYTE_W +: BYTE_W]} + {1'b0, rd1_q[k*BYTE_W +: BYTE_W]};
      blend[k*BYTE_W +: BYTE_W] = sum[BYTE_W:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_rd_valid_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else if (advance) begin
      mem_rd_valid_q <= sb_valid_q[DIV_LAT-1] && sb_q[DIV_LAT-1].render;
      out_valid_q    <= mem_rd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      px_q <= blend;
    end
  end

  assign out_valid_o = out_valid_q;
  assign px_byte0_o  = px_q[0*BYTE_W +: BYTE_W];
  assign px_byte1_o  = px_q[1*BYTE_W +: BYTE_W];
  assign px_byte2_o  = px_q[2*BYTE_W +: BYTE_W];

endmodule

[sv/dual_nearest_scale_blend.sv]
// Top level of the dual nearest scale blend block: configuration registers and wiring.
//
// This block holds two source images of up to 256 by 256 three-byte pixels and renders
// an output raster by scaling each source to the output size with nearest-neighbor
// mapping, then averaging the two mapped pixels byte by byte. A write item (func_i low)
// stores one pixel into the source named by src_sel_i and yields no result; a render
// item (func_i high) yields exactly one result. One item of either kind is taken per
// clock while in_stall_o is low, and results come out in the order of their items, one
// per clock while out_stall_i is low. A render passes the bit-per-stage divider that
// turns the scaled coordinate into a source index, the registered read of the image
// memory and the output register. A small queue between the input side and the scaling
// pipeline lets the input keep flowing while the output is stalled, until it is full.
// Sizes written through the configuration port are clamped on the way in: zero acts as
// one; a source size keeps its low nine bits, and above 256 acts as 256. Configuration
// should only be written while no item is in flight. A source pixel must be written
// before any render maps onto it; the image memories are not cleared after reset.
module dual_nearest_scale_blend (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dnsb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dnsb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic                            src_sel_i,
  input  logic [dnsb_pkg::COORD_W-1:0]    src_col_i,
  input  logic [dnsb_pkg::COORD_W-1:0]    src_row_i,
  input  logic [dnsb_pkg::BYTE_W-1:0]     wr_byte0_i,
  input  logic [dnsb_pkg::BYTE_W-1:0]     wr_byte1_i,
  input  logic [dnsb_pkg::BYTE_W-1:0]     wr_byte2_i,
  input  logic [dnsb_pkg::OUT_W-1:0]      out_col_i,
  input  logic [dnsb_pkg::OUT_W-1:0]      out_row_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [dnsb_pkg::BYTE_W-1:0]     px_byte0_o,
  output logic [dnsb_pkg::BYTE_W-1:0]     px_byte1_o,
  output logic [dnsb_pkg::BYTE_W-1:0]     px_byte2_o
);
  import dnsb_pkg::*;

  dnsb_sizes_t sizes_q;
  dnsb_sizes_t sizes_d;
  dnsb_item_t  front_item;
  dnsb_item_t  queue_item;
  logic        queue_valid;
  logic        queue_full;
  logic        back_take;

  // Each size register keeps its clamped value, so the datapath never sees zero.
  always_comb begin
    sizes_d = sizes_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SRC0_WIDTH:  sizes_d.src0_w = fit_src(cfg_data_i[SIZE_W-1:0]);
        CFG_SRC0_HEIGHT: sizes_d.src0_h = fit_src(cfg_data_i[SIZE_W-1:0]);
        CFG_SRC1_WIDTH:  sizes_d.src1_w = fit_src(cfg_data_i[SIZE_W-1:0]);
        CFG_SRC1_HEIGHT: sizes_d.src1_h = fit_src(cfg_data_i[SIZE_W-1:0]);
        CFG_OUT_WIDTH:   sizes_d.out_w  = fit_out(cfg_data_i[OUT_W-1:0]);
        CFG_OUT_HEIGHT:  sizes_d.out_h  = fit_out(cfg_data_i[OUT_W-1:0]);
        default:         sizes_d = sizes_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sizes_q.src0_w <= SRC_SIZE_RST;
      sizes_q.src0_h <= SRC_SIZE_RST;
      sizes_q.src1_w <= SRC_SIZE_RST;
      sizes_q.src1_h <= SRC_SIZE_RST;
      sizes_q.out_w  <= OUT_W_RST;
      sizes_q.out_h  <= OUT_H_RST;
    end else begin
      sizes_q <= sizes_d;
    end
  end

  // The front end classifies the item and forms the coordinate products.
  dnsb_front u_front (
    .func_i,
    .src_sel_i,
    .src_col_i,
    .src_row_i,
    .wr_byte0_i,
    .wr_byte1_i,
    .wr_byte2_i,
    .out_col_i,
    .out_row_i,
    .sizes_i (sizes_q),
    .item_o  (front_item)
  );

  // Input transfers are refused only while the queue is full.
  assign in_stall_o = queue_full;

  dnsb_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (in_valid_i),
    .item_i  (front_item),
    .pop_i   (back_take),
    .item_o  (queue_item),
    .valid_o (queue_valid),
    .full_o  (queue_full)
  );

  // The back end divides, reads both images and blends the two pixels.
  dnsb_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i     (queue_valid),
    .item_i      (queue_item),
    .take_o      (back_take),
    .sizes_i     (sizes_q),
    .out_valid_o,
    .out_stall_i,
    .px_byte0_o,
    .px_byte1_o,
    .px_byte2_o
  );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the dual nearest scale blend block.
module tb_top;
  import dnsb_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 10;
  // Covers a write that is still in flight once the last expected result has shown up.
  localparam int DRAIN_CYCLES = 24;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 110;
  localparam int IMG_DEPTH    = SRC_MAX_DIM * SRC_MAX_DIM;
  localparam int OUT_MAX      = (1 << OUT_W) - 1;

  // One input item with every field of the input side, as it is driven onto the ports.
  typedef struct packed {
    func_e              func;
    logic               sel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   pix;
    logic [OUT_W-1:0]   x;
    logic [OUT_W-1:0]   y;
  } pixel_cmd_t;

  // The scoreboard keeps its own copy of both source images and of the size registers.
  // Every accepted write updates the image copy, and every accepted render queues the
  // blended pixel that the block must return. Results arrive in order, so the oldest
  // queued pixel is always the one to compare against.
  class blend_scoreboard;
    logic [PIX_W-1:0] image [2][IMG_DEPTH];
    bit               written [2][IMG_DEPTH];
    int unsigned      src_w [2];
    int unsigned      src_h [2];
    int unsigned      out_w;
    int unsigned      out_h;
    logic [PIX_W-1:0] blend_q [$];
    int               errors;

    function new();
      src_w  = '{SRC_SIZE_RST, SRC_SIZE_RST};
      src_h  = '{SRC_SIZE_RST, SRC_SIZE_RST};
      out_w  = OUT_W_RST;
      out_h  = OUT_H_RST;
      errors = 0;
    endfunction

    // A size of zero behaves as one, and a size above the limit behaves as the limit.
    function int unsigned fit_size(int unsigned v, int unsigned max_v);
      if (v == 0) return 1;
      if (v > max_v) return max_v;
      return v;
    endfunction

    // Nearest-neighbor mapping of one output coordinate onto a source axis. A coordinate
    // beyond the output raster would land past the source edge, so it is held at the
    // last source column or row.
    function int unsigned scale_pos(int unsigned pos, int unsigned src, int unsigned outv);
      int unsigned s;
      int unsigned o;
      int unsigned m;
      s = fit_size(src, SRC_MAX_DIM);
      o = fit_size(outv, OUT_MAX);
      m = (pos * s) / o;
      if (m >= s) m = s - 1;
      return m;
    endfunction

    function int unsigned source_addr(bit sel, int unsigned x, int unsigned y);
      return scale_pos(y, src_h[sel], out_h) * SRC_MAX_DIM + scale_pos(x, src_w[sel], out_w);
    endfunction

    // Only the low nine bits of a source size register are kept.
    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_SRC0_WIDTH:  src_w[0] = v[SIZE_W-1:0];
        CFG_SRC0_HEIGHT: src_h[0] = v[SIZE_W-1:0];
        CFG_SRC1_WIDTH:  src_w[1] = v[SIZE_W-1:0];
        CFG_SRC1_HEIGHT: src_h[1] = v[SIZE_W-1:0];
        CFG_OUT_WIDTH:   out_w    = v;
        CFG_OUT_HEIGHT:  out_h    = v;
        default: ;
      endcase
    endfunction

    function void note_input(pixel_cmd_t c);
      int unsigned      addr;
      logic [PIX_W-1:0] p0;
      logic [PIX_W-1:0] p1;
      logic [PIX_W-1:0] blend;
      logic [BYTE_W:0]  sum;
      if (c.func == FUNC_WRITE) begin
        addr = {c.row, c.col};
        image[c.sel][addr]   = c.pix;
        written[c.sel][addr] = 1'b1;
      end else begin
        p0 = image[0][source_addr(0, c.x, c.y)];
        p1 = image[1][source_addr(1, c.x, c.y)];
        for (int k = 0; k < 3; k++) begin
          sum = {1'b0, p0[k*BYTE_W +: BYTE_W]} + {1'b0, p1[k*BYTE_W +: BYTE_W]};
          blend[k*BYTE_W +: BYTE_W] = sum[BYTE_W:1];
        end
        blend_q.push_back(blend);
      end
    endfunction

    function void check_result(logic [PIX_W-1:0] got);
      logic [PIX_W-1:0] want;
      if (blend_q.size() == 0) begin
        $display("%0t: result %06h arrived with none expected", $time, got);
        errors++;
        return;
      end
      want = blend_q.pop_front();
      for (int k = 0; k < 3; k++) begin
        if (got[k*BYTE_W +: BYTE_W] !== want[k*BYTE_W +: BYTE_W]) begin
          $display("%0t: px_byte%0d mismatch, expected %02h, actual %02h", $time, k,
                   want[k*BYTE_W +: BYTE_W], got[k*BYTE_W +: BYTE_W]);
          errors++;
        end
      end
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  func      = 1'b0;
  logic                  src_sel   = 1'b0;
  logic [COORD_W-1:0]    src_col   = '0;
  logic [COORD_W-1:0]    src_row   = '0;
  logic [BYTE_W-1:0]     wr_byte0  = '0;
  logic [BYTE_W-1:0]     wr_byte1  = '0;
  logic [BYTE_W-1:0]     wr_byte2  = '0;
  logic [OUT_W-1:0]      out_col   = '0;
  logic [OUT_W-1:0]      out_row   = '0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [BYTE_W-1:0]     px_byte0;
  logic [BYTE_W-1:0]     px_byte1;
  logic [BYTE_W-1:0]     px_byte2;

  // Chance, in percent, that the sender holds back a cycle and that the receiver stalls.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count;

  blend_scoreboard sb = new();

  dual_nearest_scale_blend i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .func_i     (func),
    .src_sel_i  (src_sel),
    .src_col_i  (src_col),
    .src_row_i  (src_row),
    .wr_byte0_i (wr_byte0),
    .wr_byte1_i (wr_byte1),
    .wr_byte2_i (wr_byte2),
    .out_col_i  (out_col),
    .out_row_i  (out_row),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .px_byte0_o (px_byte0),
    .px_byte1_o (px_byte1),
    .px_byte2_o (px_byte2)
  );

  always begin
    clk_i = 1'b0;
    #CLK_HALF;
    clk_i = 1'b1;
    #CLK_HALF;
  end

  // The receiver decides at each falling edge whether it stalls the next edge.
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // A result transfer happens at a rising edge with valid high and stall low. The values
  // seen here are the ones that settled before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_result({px_byte2, px_byte1, px_byte0});
    end
  end

  // All tasks below start and end at a falling edge. An input transfer is noted in the
  // scoreboard at the very edge that accepts it, so the image copy is always current
  // when the next render is planned.
  task automatic send_item(pixel_cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    func     <= c.func;
    src_sel  <= c.sel;
    src_col  <= c.col;
    src_row  <= c.row;
    wr_byte0 <= c.pix[0*BYTE_W +: BYTE_W];
    wr_byte1 <= c.pix[1*BYTE_W +: BYTE_W];
    wr_byte2 <= c.pix[2*BYTE_W +: BYTE_W];
    out_col  <= c.x;
    out_row  <= c.y;
    do @(posedge clk_i); while (in_stall);
    sb.note_input(c);
    @(negedge clk_i);
  endtask

  // Fields that the item's function does not use still get random values.
  function automatic pixel_cmd_t random_cmd();
    pixel_cmd_t c;
    c.func = FUNC_WRITE;
    c.sel  = 1'($urandom());
    c.col  = COORD_W'($urandom());
    c.row  = COORD_W'($urandom());
    c.pix  = PIX_W'($urandom());
    c.x    = OUT_W'($urandom());
    c.y    = OUT_W'($urandom());
    return c;
  endfunction

  task automatic send_write(bit sel, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                            logic [PIX_W-1:0] pix);
    pixel_cmd_t c;
    c      = random_cmd();
    c.func = FUNC_WRITE;
    c.sel  = sel;
    c.col  = col;
    c.row  = row;
    c.pix  = pix;
    send_item(c);
  endtask

  // Source pixels must hold data before a render lands on them, so any mapped pixel that
  // has never been written gets a random value first.
  task automatic send_render(logic [OUT_W-1:0] x, logic [OUT_W-1:0] y);
    pixel_cmd_t  c;
    int unsigned addr;
    for (int s = 0; s < 2; s++) begin
      addr = sb.source_addr(s, x, y);
      if (!sb.written[s][addr]) begin
        send_write(s, COORD_W'(addr), COORD_W'(addr >> COORD_W), PIX_W'($urandom()));
      end
    end
    c      = random_cmd();
    c.func = FUNC_RENDER;
    c.x    = x;
    c.y    = y;
    send_item(c);
  endtask

  // The caller lowers the write enable after the last register of a group.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    sb.set_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic program_sizes(logic [CFG_DATA_W-1:0] s0w, logic [CFG_DATA_W-1:0] s0h,
                               logic [CFG_DATA_W-1:0] s1w, logic [CFG_DATA_W-1:0] s1h,
                               logic [CFG_DATA_W-1:0] ow, logic [CFG_DATA_W-1:0] oh);
    write_reg(CFG_SRC0_WIDTH, s0w);
    write_reg(CFG_SRC0_HEIGHT, s0h);
    write_reg(CFG_SRC1_WIDTH, s1w);
    write_reg(CFG_SRC1_HEIGHT, s1h);
    write_reg(CFG_OUT_WIDTH, ow);
    write_reg(CFG_OUT_HEIGHT, oh);
    cfg_we <= 1'b0;
  endtask

  // Stops sending, waits for every pending result, then lets a trailing write finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.blend_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Source sizes are mostly small so that renders hit pixels written earlier; a few go
  // past 256 or use the upper bits of the data word that the register drops.
  function automatic logic [CFG_DATA_W-1:0] rand_src_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CFG_DATA_W'(SRC_MAX_DIM);
      2:       return CFG_DATA_W'($urandom_range(SRC_MAX_DIM + 1, OUT_MAX));
      3, 4:    return CFG_DATA_W'($urandom_range(1, SRC_MAX_DIM));
      default: return CFG_DATA_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_out_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CFG_DATA_W'(OUT_MAX);
      2, 3:    return CFG_DATA_W'($urandom_range(1, OUT_MAX));
      default: return CFG_DATA_W'($urandom_range(1, 64));
    endcase
  endfunction

  // Mostly a coordinate inside the raster, sometimes its last one, and sometimes any
  // value at all so that coordinates past the raster get saturated.
  function automatic logic [OUT_W-1:0] pick_coord(int unsigned span);
    int unsigned lim;
    lim = sb.fit_size(span, OUT_MAX);
    case ($urandom_range(9))
      0:       return OUT_W'($urandom());
      1:       return OUT_W'(lim - 1);
      default: return OUT_W'($urandom_range(lim - 1));
    endcase
  endfunction

  // Half of the items are renders; most writes fill the part of a source that the
  // current sizes can reach, and the rest land anywhere in storage.
  task automatic run_mix(int n);
    int unsigned pick;
    bit          sel;
    repeat (n) begin
      pick = $urandom_range(99);
      sel  = 1'($urandom());
      if (pick < 50) begin
        send_render(pick_coord(sb.out_w), pick_coord(sb.out_h));
      end else if (pick < 85) begin
        send_write(sel,
                   COORD_W'($urandom_range(sb.fit_size(sb.src_w[sel], SRC_MAX_DIM) - 1)),
                   COORD_W'($urandom_range(sb.fit_size(sb.src_h[sel], SRC_MAX_DIM) - 1)),
                   PIX_W'($urandom()));
      end else begin
        send_write(sel, COORD_W'($urandom()), COORD_W'($urandom()), PIX_W'($urandom()));
      end
    end
  endtask

  // Ends the run if it hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under the reset sizes, 256 by 256 sources onto a 1366 by 768 raster.
    // Black and white corner pixels give a blend of 7f in every byte.
    send_write(0, '0, '0, '0);
    send_write(1, '0, '0, '1);
    send_render('0, '0);
    // The far corner of the raster maps onto the last source pixel.
    send_write(0, '1, '1, '1);
    send_write(1, '1, '1, 24'h01fe80);
    send_render(OUT_W'(OUT_W_RST - 1), OUT_W'(OUT_H_RST - 1));
    // Coordinates past the raster are held at the last source column and row.
    send_render('1, '1);
    send_render(OUT_W'(OUT_W_RST), '0);
    // Odd byte sums round down; a nearby output pixel still maps onto the origin.
    send_write(1, '0, '0, 24'haa5501);
    send_write(0, '0, '0, 24'h55aaff);
    send_render(OUT_W'(1), OUT_W'(1));
    send_render('0, '0);
    send_write(0, 8'h80, 8'h40, 24'h123456);
    send_write(1, 8'h80, 8'h40, 24'hfedcba);
    send_render(OUT_W'(683), OUT_W'(192));

    // Each phase reprograms the sizes while the block is idle, then runs a random mix
    // under one of four idling patterns. The first phases take the extremes: all sizes
    // zero, all sizes at their top, full sources onto a single output pixel, and single
    // pixel sources onto the largest raster. The last phase returns to the reset values.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:        program_sizes('0, '0, '0, '0, '0, '0);
        1:        program_sizes(12'h1ff, 12'h1ff, 12'h1ff, 12'h1ff, '1, '1);
        2:        program_sizes(12'd256, 12'd256, 12'd256, 12'd256, 12'd1, 12'd1);
        3:        program_sizes(12'd1, 12'd1, 12'd1, 12'd1, '1, '1);
        PHASES-1: program_sizes(CFG_DATA_W'(SRC_SIZE_RST), CFG_DATA_W'(SRC_SIZE_RST),
                                CFG_DATA_W'(SRC_SIZE_RST), CFG_DATA_W'(SRC_SIZE_RST),
                                OUT_W_RST, OUT_H_RST);
        default:  program_sizes(rand_src_size(), rand_src_size(), rand_src_size(),
                                rand_src_size(), rand_out_size(), rand_out_size());
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      run_mix(PHASE_ITEMS);
    end

    settle();
    if (sb.blend_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.blend_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
